// ===== src/dtab_pkg.sv =====
// ----------------------------------------------------------------------------
// dtab_pkg: shared types and constants of the descriptor table allocator
// Item layouts, operation and status codes, slot states, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package dtab_pkg;

  // Default sizes for the top level parameters
  localparam int unsigned DEF_TABLE_DEPTH = 32;
  localparam int unsigned DEF_HANDLE_BITS = 16;
  localparam int unsigned DEF_FLAG_BITS   = 8;

  // Fixed field widths of the item channels
  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned STATUS_W = 3;

  // Configuration port
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] CLOEXEC_ADDR  = 2'd0;
  localparam logic [FLAGS_W-1:0] CLOEXEC_RESET = 8'h01;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_COMMIT = 3'd1,
    OP_PUT    = 3'd2,
    OP_CLOSE  = 3'd3,
    OP_GET    = 3'd4,
    OP_SWEEP  = 3'd5,
    OP_GETF   = 3'd6,
    OP_SETF   = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 3'd0,
    STS_BADF   = 3'd1,
    STS_BUSY   = 3'd2,
    STS_FULL   = 3'd3,
    STS_NOTRES = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_RESV = 2'd1,
    SLOT_OPEN = 2'd2
  } slot_st_e;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [FLAGS_W-1:0]  flags;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [FLAGS_W-1:0]  flags_out;
    logic                acquire;
    logic                release_res;
    logic                last;
  } out_item_t;

  // Write strobes from the sequencer to the slot store
  typedef struct packed {
    logic we_handle;
    logic we_flags;
  } mem_ctl_t;

endpackage : dtab_pkg

`default_nettype wire

// ===== src/dtab_mem.sv =====
// ----------------------------------------------------------------------------
// dtab_mem: handle and flag store of the descriptor table
// One write and one registered read per cycle; flags read as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module dtab_mem #(
  parameter int unsigned TABLE_DEPTH = dtab_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned HANDLE_BITS = dtab_pkg::DEF_HANDLE_BITS,
  parameter int unsigned FLAG_BITS   = dtab_pkg::DEF_FLAG_BITS,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire dtab_pkg::mem_ctl_t ctl_i,
  input  wire [IDX_W-1:0]         waddr_i,
  input  wire [IDX_W-1:0]         raddr_i,
  input  wire [HANDLE_BITS-1:0]   handle_i,
  input  wire [FLAG_BITS-1:0]     flags_i,
  output logic [HANDLE_BITS-1:0]  handle_o,
  output logic [FLAG_BITS-1:0]    flags_o
);
  import dtab_pkg::*;

  logic [HANDLE_BITS-1:0] handle_mem [TABLE_DEPTH];
  logic [FLAG_BITS-1:0]   flags_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] fvalid_q;
  logic                   fvalid_rd_q;
  logic [HANDLE_BITS-1:0] handle_rd_q;
  logic [FLAG_BITS-1:0]   flags_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_handle) begin
      handle_mem[waddr_i] <= handle_i;
    end
    handle_rd_q <= handle_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_flags) begin
      flags_mem[waddr_i] <= flags_i;
    end
    flags_rd_q <= flags_mem[raddr_i];
  end

  // Flag entries start cleared: track which have been written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q    <= '0;
      fvalid_rd_q <= 1'b0;
    end else begin
      if (ctl_i.we_flags) begin
        fvalid_q[waddr_i] <= 1'b1;
      end
      fvalid_rd_q <= fvalid_q[raddr_i];
    end
  end

  assign handle_o = handle_rd_q;
  assign flags_o  = fvalid_rd_q ? flags_rd_q : '0;

endmodule : dtab_mem

`default_nettype wire

// ===== src/dtab_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtab_ctrl: sequencer of the descriptor table
// Holds slot states, walks slots with one shared index and check, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module dtab_ctrl #(
  parameter int unsigned TABLE_DEPTH = dtab_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned HANDLE_BITS = dtab_pkg::DEF_HANDLE_BITS,
  parameter int unsigned FLAG_BITS   = dtab_pkg::DEF_FLAG_BITS,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire dtab_pkg::in_item_t          in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output dtab_pkg::out_item_t              out_item_o,
  input  wire [dtab_pkg::FLAGS_W-1:0]      cloexec_mask_i,
  output dtab_pkg::mem_ctl_t               mem_ctl_o,
  output logic [IDX_W-1:0]                 mem_waddr_o,
  output logic [IDX_W-1:0]                 mem_raddr_o,
  output logic [HANDLE_BITS-1:0]           mem_handle_o,
  output logic [FLAG_BITS-1:0]             mem_flags_o,
  input  wire [HANDLE_BITS-1:0]            mem_handle_i,
  input  wire [FLAG_BITS-1:0]              mem_flags_i
);
  import dtab_pkg::*;

  localparam int unsigned HCOM = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned FCOM = (FLAG_BITS < FLAGS_W) ? FLAG_BITS : FLAGS_W;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [SLOT_W:0]   DEPTH_X  = (SLOT_W + 1)'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_AL_CHK = 6'b000100,
    S_SW_RD  = 6'b001000,
    S_SW_CHK = 6'b010000,
    S_SW_END = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  slot_st_e               status_q [TABLE_DEPTH];
  slot_st_e               status_d [TABLE_DEPTH];
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic                   slot_ok_q, slot_ok_d;
  logic [HANDLE_BITS-1:0] hw_q, hw_d;
  logic [FLAG_BITS-1:0]   fw_q, fw_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]      pend_slot_q, pend_slot_d;
  logic [HANDLE_W-1:0]    pend_handle_q, pend_handle_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   out_free;
  logic                   out_load;
  logic                   accept;
  logic [IDX_W-1:0]       rd_idx;
  slot_st_e               st_rd;
  slot_st_e               st_new;
  logic [HANDLE_W-1:0]    handle_rd_x;
  logic [FLAGS_W-1:0]     flags_rd_x;
  logic [FLAG_BITS-1:0]   mask_w;
  logic                   sweep_hit;
  out_item_t              res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Shared slot check: state read at the walk index or the request slot
  assign rd_idx = (state_q == S_AL_CHK || state_q == S_SW_CHK) ? idx_q : slot_q;
  assign st_rd  = status_q[rd_idx];

  always_comb begin
    handle_rd_x             = '0;
    handle_rd_x[HCOM-1:0]   = mem_handle_i[HCOM-1:0];
    flags_rd_x              = '0;
    flags_rd_x[FCOM-1:0]    = mem_flags_i[FCOM-1:0];
    mask_w                  = '0;
    mask_w[FCOM-1:0]        = cloexec_mask_i[FCOM-1:0];
    hw_d                    = hw_q;
    fw_d                    = fw_q;
    if (accept) begin
      hw_d           = '0;
      hw_d[HCOM-1:0] = in_item_i.handle[HCOM-1:0];
      fw_d           = '0;
      fw_d[FCOM-1:0] = in_item_i.flags[FCOM-1:0];
    end
  end

  assign sweep_hit = (st_rd == SLOT_OPEN) && ((mem_flags_i & mask_w) != '0);
  assign st_new    = (hw_q != '0) ? SLOT_OPEN : SLOT_FREE;

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    idx_d         = idx_q;
    op_d          = op_q;
    slot_d        = slot_q;
    slot_ok_d     = slot_ok_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_handle_d = pend_handle_q;
    out_load      = 1'b0;
    res           = '0;
    res.last      = 1'b1;
    mem_ctl_o     = '0;
    mem_raddr_o   = rd_idx;
    if (state_q == S_SW_RD) begin
      mem_raddr_o = idx_q;
    end

    case (state_q)
      S_IDLE: begin
        mem_raddr_o = in_item_i.slot[IDX_W-1:0];
        if (accept) begin
          op_d         = in_item_i.opcode;
          slot_d       = in_item_i.slot[IDX_W-1:0];
          slot_ok_d    = ({1'b0, in_item_i.slot} < DEPTH_X);
          idx_d        = '0;
          pend_valid_d = 1'b0;
          if (in_item_i.opcode == OP_ALLOC) begin
            state_d = S_AL_CHK;
          end else if (in_item_i.opcode == OP_SWEEP) begin
            state_d = S_SW_RD;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (!slot_ok_q) begin
          res.status = STS_BADF;
        end else begin
          case (op_q)
            OP_COMMIT: begin
              if (st_rd != SLOT_RESV) begin
                res.status = STS_NOTRES;
              end
            end
            OP_PUT: begin
              if (st_rd == SLOT_RESV) begin
                res.status = STS_BUSY;
              end else if (st_rd == SLOT_OPEN) begin
                res.handle_out  = handle_rd_x;
                res.release_res = 1'b1;
              end
            end
            OP_CLOSE: begin
              if (st_rd != SLOT_OPEN) begin
                res.status = STS_BADF;
              end else begin
                res.handle_out  = handle_rd_x;
                res.release_res = 1'b1;
              end
            end
            OP_GET: begin
              if (st_rd != SLOT_OPEN) begin
                res.status = STS_BADF;
              end else begin
                res.handle_out = handle_rd_x;
                res.acquire    = 1'b1;
              end
            end
            OP_GETF: begin
              res.flags_out = flags_rd_x;
            end
            default: begin
            end
          endcase
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (slot_ok_q) begin
            case (op_q)
              OP_COMMIT: begin
                if (st_rd == SLOT_RESV) begin
                  mem_ctl_o.we_handle = 1'b1;
                  mem_ctl_o.we_flags  = 1'b1;
                  status_d[slot_q]    = st_new;
                end
              end
              OP_PUT: begin
                if (st_rd != SLOT_RESV) begin
                  mem_ctl_o.we_handle = 1'b1;
                  mem_ctl_o.we_flags  = 1'b1;
                  status_d[slot_q]    = st_new;
                end
              end
              OP_CLOSE: begin
                if (st_rd == SLOT_OPEN) begin
                  status_d[slot_q] = SLOT_FREE;
                end
              end
              OP_SETF: begin
                mem_ctl_o.we_flags = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_AL_CHK: begin
        // Walk up from slot zero to the first free slot
        if (st_rd == SLOT_FREE) begin
          res.slot_out = SLOT_W'(idx_q);
          if (out_free) begin
            out_load        = 1'b1;
            status_d[idx_q] = SLOT_RESV;
            idx_d           = '0;
            state_d         = S_IDLE;
          end
        end else if (idx_q == IDX_LAST) begin
          res.status = STS_FULL;
          if (out_free) begin
            out_load = 1'b1;
            idx_d    = '0;
            state_d  = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SW_RD: begin
        state_d = S_SW_CHK;
      end

      S_SW_CHK: begin
        // Keep one release in hand so that the final one can carry last
        res.slot_out    = pend_slot_q;
        res.handle_out  = pend_handle_q;
        res.release_res = 1'b1;
        res.last        = 1'b0;
        if (!(sweep_hit && pend_valid_q && !out_free)) begin
          if (sweep_hit) begin
            out_load        = pend_valid_q;
            pend_valid_d    = 1'b1;
            pend_slot_d     = SLOT_W'(idx_q);
            pend_handle_d   = handle_rd_x;
            status_d[idx_q] = SLOT_FREE;
          end
          if (idx_q == IDX_LAST) begin
            idx_d   = '0;
            state_d = S_SW_END;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SW_RD;
          end
        end
      end

      S_SW_END: begin
        if (pend_valid_q) begin
          res.slot_out    = pend_slot_q;
          res.handle_out  = pend_handle_q;
          res.release_res = 1'b1;
        end
        if (out_free) begin
          out_load     = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d  = out_load || (out_valid_q && !out_ready_i);
  assign out_d        = out_load ? res : out_q;
  assign mem_waddr_o  = slot_q;
  assign mem_handle_o = hw_q;
  assign mem_flags_o  = fw_q;
  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        status_q[i] <= SLOT_FREE;
      end
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    slot_q        <= slot_d;
    slot_ok_q     <= slot_ok_d;
    hw_q          <= hw_d;
    fw_q          <= fw_d;
    pend_slot_q   <= pend_slot_d;
    pend_handle_q <= pend_handle_d;
    out_q         <= out_d;
  end

endmodule : dtab_ctrl

`default_nettype wire

// ===== src/descriptor_table_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// descriptor_table_allocator_unit: lowest-free-slot descriptor table
// Allocate, commit, put, close, get, flag access and close-on-exec sweep.
// ----------------------------------------------------------------------------
// Usage:
//   Request items enter on in_valid_i/in_ready_o/in_item_i; result items leave
//   on out_valid_o/out_ready_i/out_item_o. Every request yields one result,
//   except the sweep, which yields one result per released slot (or a single
//   empty one), the final result carrying last.
//   A single-slot operation does a registered store read, then the update.
//   Allocate walks the slot states from slot zero, one slot a cycle, up to
//   the lowest free slot. The sweep reads handle and flags of every slot
//   through the one store port, a read state then a check state per slot.
//   One request is in work at a time; the next is taken once the current
//   one has handed over its last result to the output register.
//   Reset frees every slot, clears all flags and loads cloexec_mask with 1;
//   no clearing pass is needed and requests are taken at once.
//   A stalled receiver holds the output register; the sequencer then waits
//   with its result in hand and resumes as soon as the register frees.
//   cloexec_mask sits at address 0 of the APB port; write it only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_table_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = dtab_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned HANDLE_BITS = dtab_pkg::DEF_HANDLE_BITS,
  parameter int unsigned FLAG_BITS   = dtab_pkg::DEF_FLAG_BITS
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // request items
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire dtab_pkg::in_item_t       in_item_i,
  // result items
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output dtab_pkg::out_item_t           out_item_o,
  // configuration port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [dtab_pkg::PADDR_W-1:0]   paddr,
  input  wire [dtab_pkg::PDATA_W-1:0]   pwdata,
  output logic [dtab_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dtab_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [FLAGS_W-1:0]     cloexec_mask_q;
  mem_ctl_t               mem_ctl;
  logic [IDX_W-1:0]       mem_waddr;
  logic [IDX_W-1:0]       mem_raddr;
  logic [HANDLE_BITS-1:0] mem_wr_handle;
  logic [FLAG_BITS-1:0]   mem_wr_flags;
  logic [HANDLE_BITS-1:0] mem_rd_handle;
  logic [FLAG_BITS-1:0]   mem_rd_flags;

  // Configuration register: no wait states, write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == CLOEXEC_ADDR) ? PDATA_W'(cloexec_mask_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cloexec_mask_q <= CLOEXEC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == CLOEXEC_ADDR)) begin
      cloexec_mask_q <= pwdata[FLAGS_W-1:0];
    end
  end

  // Sequencer: slot states, walk index and result register
  dtab_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .FLAG_BITS   (FLAG_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o),
    .cloexec_mask_i (cloexec_mask_q),
    .mem_ctl_o      (mem_ctl),
    .mem_waddr_o    (mem_waddr),
    .mem_raddr_o    (mem_raddr),
    .mem_handle_o   (mem_wr_handle),
    .mem_flags_o    (mem_wr_flags),
    .mem_handle_i   (mem_rd_handle),
    .mem_flags_i    (mem_rd_flags)
  );

  // Handle and flag store with registered read
  dtab_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .FLAG_BITS   (FLAG_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .waddr_i  (mem_waddr),
    .raddr_i  (mem_raddr),
    .handle_i (mem_wr_handle),
    .flags_i  (mem_wr_flags),
    .handle_o (mem_rd_handle),
    .flags_o  (mem_rd_flags)
  );

endmodule : descriptor_table_allocator_unit

`default_nettype wire

// ===== tb/sv/descriptor_table_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// descriptor_table_allocator_checker: result checker for the descriptor table
// Watches the request, result and configuration channels, keeps its own copy
// of the slot table, works out the results of every accepted request and
// compares them field by field, oldest first, with what the block returns.
// ----------------------------------------------------------------------------
module descriptor_table_allocator_checker
  import dtab_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS,
  parameter int unsigned FLAG_BITS   = DEF_FLAG_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_item_t              out_item_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic                   pready_i,
  input  logic [PADDR_W-1:0]     paddr_i,
  input  logic [PDATA_W-1:0]     pwdata_i,
  input  logic [PDATA_W-1:0]     prdata_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output logic [TABLE_DEPTH-1:0] resv_map_o,
  output logic [TABLE_DEPTH-1:0] open_map_o
);

  localparam logic [HANDLE_W-1:0] HANDLE_KEEP = (HANDLE_BITS >= HANDLE_W) ?
      {HANDLE_W{1'b1}} : HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);
  localparam logic [FLAGS_W-1:0] FLAG_KEEP = (FLAG_BITS >= FLAGS_W) ?
      {FLAGS_W{1'b1}} : FLAGS_W'((64'd1 << FLAG_BITS) - 64'd1);

  slot_st_e            slot_state [TABLE_DEPTH];
  logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH];
  logic [FLAGS_W-1:0]  slot_flags [TABLE_DEPTH];
  logic [FLAGS_W-1:0]  cloexec_mask;
  out_item_t           expected_results [$];
  int unsigned         fails;

  function automatic out_item_t make_result(input status_e st, input int unsigned sl,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic [FLAGS_W-1:0] f,
                                            input logic acq, input logic rel,
                                            input logic fin);
    out_item_t r;
    r.status      = st;
    r.slot_out    = SLOT_W'(sl);
    r.handle_out  = h;
    r.flags_out   = f;
    r.acquire     = acq;
    r.release_res = rel;
    r.last        = fin;
    return r;
  endfunction

  // Apply one request to the table copy and queue the results it causes
  task automatic table_step(input in_item_t it);
    op_e                 op;
    logic [HANDLE_W-1:0] h;
    logic [FLAGS_W-1:0]  f;
    int                  idx;
    int                  found;
    slot_st_e            cur;
    logic                held_valid;
    out_item_t           held;
    op         = op_e'(it.opcode);
    h          = it.handle & HANDLE_KEEP;
    f          = it.flags & FLAG_KEEP;
    idx        = (it.slot < TABLE_DEPTH) ? int'(it.slot) : 0;
    cur        = slot_state[idx];
    found      = -1;
    held_valid = 1'b0;
    held       = '0;
    case (op)
      OP_ALLOC: begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (found < 0 && slot_state[k] == SLOT_FREE) found = k;
        end
        if (found >= 0) begin
          slot_state[found] = SLOT_RESV;
          expected_results.push_back(make_result(STS_OK, found, '0, '0, 0, 0, 1));
        end else begin
          expected_results.push_back(make_result(STS_FULL, 0, '0, '0, 0, 0, 1));
        end
      end
      OP_SWEEP: begin
        // hold each release back one step so that the final one can carry last
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (slot_state[k] == SLOT_OPEN && (slot_flags[k] & cloexec_mask) != '0) begin
            slot_state[k] = SLOT_FREE;
            if (held_valid) expected_results.push_back(held);
            held       = make_result(STS_OK, k, slot_handle[k], '0, 0, 1, 0);
            held_valid = 1'b1;
          end
        end
        held.last = 1'b1;
        expected_results.push_back(held);
      end
      default: begin
        if (it.slot >= TABLE_DEPTH) begin
          expected_results.push_back(make_result(STS_BADF, 0, '0, '0, 0, 0, 1));
        end else begin
          case (op)
            OP_COMMIT: begin
              if (cur != SLOT_RESV) begin
                expected_results.push_back(make_result(STS_NOTRES, 0, '0, '0, 0, 0, 1));
              end else begin
                slot_handle[idx] = h;
                slot_flags[idx]  = f;
                slot_state[idx]  = (h != '0) ? SLOT_OPEN : SLOT_FREE;
                expected_results.push_back(make_result(STS_OK, 0, '0, '0, 0, 0, 1));
              end
            end
            OP_PUT: begin
              if (cur == SLOT_RESV) begin
                expected_results.push_back(make_result(STS_BUSY, 0, '0, '0, 0, 0, 1));
              end else begin
                if (cur == SLOT_OPEN) begin
                  expected_results.push_back(
                      make_result(STS_OK, 0, slot_handle[idx], '0, 0, 1, 1));
                end else begin
                  expected_results.push_back(make_result(STS_OK, 0, '0, '0, 0, 0, 1));
                end
                slot_handle[idx] = h;
                slot_flags[idx]  = f;
                slot_state[idx]  = (h != '0) ? SLOT_OPEN : SLOT_FREE;
              end
            end
            OP_CLOSE: begin
              if (cur != SLOT_OPEN) begin
                expected_results.push_back(make_result(STS_BADF, 0, '0, '0, 0, 0, 1));
              end else begin
                slot_state[idx] = SLOT_FREE;
                expected_results.push_back(
                    make_result(STS_OK, 0, slot_handle[idx], '0, 0, 1, 1));
              end
            end
            OP_GET: begin
              if (cur != SLOT_OPEN) begin
                expected_results.push_back(make_result(STS_BADF, 0, '0, '0, 0, 0, 1));
              end else begin
                expected_results.push_back(
                    make_result(STS_OK, 0, slot_handle[idx], '0, 1, 0, 1));
              end
            end
            OP_GETF: begin
              expected_results.push_back(make_result(STS_OK, 0, '0, slot_flags[idx], 0, 0, 1));
            end
            default: begin
              slot_flags[idx] = f;
              expected_results.push_back(make_result(STS_OK, 0, '0, '0, 0, 0, 1));
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t              want;
    logic [TABLE_DEPTH-1:0] resv_v;
    logic [TABLE_DEPTH-1:0] open_v;
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        slot_state[k]  = SLOT_FREE;
        slot_handle[k] = '0;
        slot_flags[k]  = '0;
      end
      cloexec_mask = CLOEXEC_RESET;
      expected_results.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      resv_map_o   <= '0;
      open_map_o   <= '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: 0x%0h", out_item_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_item_i.status);
          check_field("slot_out", want.slot_out, out_item_i.slot_out);
          check_field("handle_out", want.handle_out, out_item_i.handle_out);
          check_field("flags_out", want.flags_out, out_item_i.flags_out);
          check_field("acquire", want.acquire, out_item_i.acquire);
          check_field("release_res", want.release_res, out_item_i.release_res);
          check_field("last", want.last, out_item_i.last);
        end
      end
      if (in_valid_i && in_ready_i) table_step(in_item_i);
      if (psel_i && penable_i && pready_i && paddr_i == CLOEXEC_ADDR) begin
        if (pwrite_i) cloexec_mask = pwdata_i[FLAGS_W-1:0];
        else check_field("prdata", PDATA_W'(cloexec_mask), prdata_i);
      end
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        resv_v[k] = (slot_state[k] == SLOT_RESV);
        open_v[k] = (slot_state[k] == SLOT_OPEN);
      end
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
      resv_map_o   <= resv_v;
      open_map_o   <= open_v;
    end
  end

endmodule

// ===== tb/sv/descriptor_table_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// descriptor_table_allocator_unit_tb: regression bench for the descriptor table
// Drives a directed opening and several random phases of table requests under
// different close-on-exec masks, with random idling on both channels, one long
// receiver hold-off and idle pauses; the checker beside the block does the
// predicting and comparing, and this top gives the verdict.
// ----------------------------------------------------------------------------
module descriptor_table_allocator_unit_tb;
  import dtab_pkg::*;

  localparam int unsigned DEPTH        = DEF_TABLE_DEPTH;
  // Worst run: every request a full sweep with every result stalled, several
  // times over, plus the long hold-off.
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 2 * DEPTH + 16;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  in_item_t           req_item  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  out_item_t          res_item;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned        fail_count;
  int unsigned        pending;
  logic [DEPTH-1:0]   resv_map;
  logic [DEPTH-1:0]   open_map;

  // Idling controls, set by the stimulus process
  logic               gaps_on   = 1'b1;
  logic               hold_req  = 1'b0;
  logic               hold_done = 1'b0;
  int unsigned        cycles    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  descriptor_table_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_item_i   (req_item),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_item_o  (res_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  descriptor_table_allocator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_item_i    (req_item),
    .out_valid_i  (res_valid),
    .out_ready_i  (res_ready),
    .out_item_i   (res_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .resv_map_o   (resv_map),
    .open_map_o   (open_map)
  );

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts while gaps are on, one long hold-off on
  // request so that the block fills up and backs up its request channel.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done <= 1'b1;
        res_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t req(input op_e op, input int unsigned sl,
                                   input logic [HANDLE_W-1:0] h,
                                   input logic [FLAGS_W-1:0] f);
    in_item_t it;
    it.opcode = op;
    it.slot   = SLOT_W'(sl);
    it.handle = h;
    it.flags  = f;
    return it;
  endfunction

  // Offer one item and hold it until taken; maybe drop valid for a burst after
  task automatic push(input in_item_t it);
    req_item  <= it;
    req_valid <= 1'b1;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One APB access to the mask register: setup cycle, then access cycle;
  // the caller drops psel once its accesses are done
  task automatic mask_access(input logic wr, input logic [FLAGS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CLOEXEC_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_mask(input logic [FLAGS_W-1:0] value);
    mask_access(1'b1, value);
    mask_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random set bit of a slot map, or -1 when the map is empty
  function automatic int pick_slot(input logic [DEPTH-1:0] map);
    int start;
    int idx;
    start = $urandom_range(0, DEPTH - 1);
    for (int k = 0; k < DEPTH; k++) begin
      idx = (start + k) % DEPTH;
      if (map[idx]) return idx;
    end
    return -1;
  endfunction

  // Mostly well-formed traffic: commits aim at reserved slots, put, close and
  // get mostly at open ones; the rest hits arbitrary or invalid slots.
  task automatic run_random(input int unsigned count, input int unsigned alloc_pct);
    in_item_t it;
    op_e      op;
    int       sl;
    int       roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 28)      op = OP_COMMIT;
        else if (roll < 44) op = OP_PUT;
        else if (roll < 56) op = OP_CLOSE;
        else if (roll < 68) op = OP_GET;
        else if (roll < 74) op = OP_SWEEP;
        else if (roll < 87) op = OP_GETF;
        else                op = OP_SETF;
      end
      sl = -1;
      if (op == OP_COMMIT && $urandom_range(0, 99) < 85) sl = pick_slot(resv_map);
      if ((op == OP_PUT || op == OP_CLOSE || op == OP_GET) && $urandom_range(0, 99) < 60)
        sl = pick_slot(open_map);
      if (sl < 0) sl = $urandom_range(0, DEPTH - 1);
      if ($urandom_range(0, 99) < 8) sl = $urandom_range(DEPTH, 63);
      it.opcode = op;
      it.slot   = SLOT_W'(sl);
      roll      = $urandom_range(0, 99);
      if (roll < 10)      it.handle = '0;
      else if (roll < 15) it.handle = '1;
      else                it.handle = HANDLE_W'($urandom);
      it.flags  = FLAGS_W'($urandom_range(0, 255));
      push(it);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under the reset mask
    push(req(OP_GETF, 0, '0, '0));              // flags cleared by reset
    push(req(OP_SWEEP, 0, '0, '0));             // nothing open: empty result
    push(req(OP_ALLOC, 0, '0, '0));             // lowest free is slot 0
    push(req(OP_ALLOC, 63, 16'hFFFF, 8'hFF));   // fields ignored, slot 1
    push(req(OP_COMMIT, 0, 16'hFFFF, 8'h01));
    push(req(OP_COMMIT, 5, 16'h0042, 8'h00));   // slot not reserved
    push(req(OP_COMMIT, 1, 16'h0000, 8'hFF));   // handle zero leaves it free
    push(req(OP_PUT, 2, 16'h1234, 8'h00));      // put on a free slot
    push(req(OP_ALLOC, 0, '0, '0));             // slot 1 again
    push(req(OP_PUT, 1, 16'h5555, 8'h10));      // busy while reserved
    push(req(OP_PUT, 2, 16'hABCD, 8'h81));      // replace, old handle released
    push(req(OP_GET, 2, '0, '0));
    push(req(OP_GET, 3, '0, '0));               // free slot
    push(req(OP_GET, 1, '0, '0));               // reserved slot
    push(req(OP_CLOSE, 1, '0, '0));             // reserved slot
    push(req(OP_CLOSE, 3, '0, '0));             // free slot
    push(req(OP_SETF, 31, '0, 8'hFF));
    push(req(OP_GETF, 1, '0, '0));              // flags of a reserved slot
    push(req(OP_PUT, 31, 16'h0001, 8'h00));     // open, but not marked
    push(req(OP_GET, 32, '0, '0));              // invalid slots from here
    push(req(OP_COMMIT, 63, 16'h7777, 8'h01));
    push(req(OP_PUT, 63, 16'h8888, 8'hFF));
    push(req(OP_CLOSE, 32, '0, '0));
    push(req(OP_GETF, 63, '0, '0));
    push(req(OP_SETF, 63, '0, 8'hFF));
    push(req(OP_SWEEP, 0, '0, '0));             // releases slots 0 and 2
    push(req(OP_CLOSE, 31, '0, '0));
    push(req(OP_PUT, 4, 16'h0000, 8'h55));      // handle zero on a free slot
    wait_idle();

    // Every flag bit marks a slot
    set_mask(8'hFF);
    run_random(90, 25);
    wait_idle();

    // Nothing is swept: allocate hard to fill the table, under a long hold-off
    set_mask(8'h00);
    hold_req <= 1'b1;
    run_random(70, 60);
    wait_idle();

    set_mask(8'h80);
    run_random(80, 25);
    wait_idle();

    // Closing stretch with no idling on either side
    set_mask(FLAGS_W'($urandom_range(0, 255)));
    gaps_on <= 1'b0;
    run_random(80, 25);
    wait_idle();

    // Let any stray result show up before the verdict
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/dtab_pkg.sv
src/dtab_mem.sv
src/dtab_ctrl.sv
src/descriptor_table_allocator_unit.sv
tb/sv/descriptor_table_allocator_checker.sv
tb/sv/descriptor_table_allocator_unit_tb.sv
